### sv/sorted_set_insert_defines.svh
// assertion macros for the sorted set insert block
`ifndef SORTED_SET_INSERT_DEFINES_SVH
`define SORTED_SET_INSERT_DEFINES_SVH

`ifndef SYNTH
// condition that must hold at every clock edge out of reset
`define SSET_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted set insert check failed");
// antecedent in one cycle implies consequent in the next
`define SSET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted set insert check failed");
`else
`define SSET_ASSERT(lbl, cond)
`define SSET_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/sset_pkg.sv
// shared types and constants of the sorted set insert block
`default_nettype none
package sset_pkg;

  localparam int unsigned SSET_CAPACITY = 64;
  localparam int unsigned SSET_VAL_W    = 32;
  localparam int unsigned SSET_FIELD_W  = 7;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_CMP  = 3'b010,
    FSM_UPD  = 3'b100
  } fsm_e;

  // what one cell hands to its upper neighbor
  typedef struct packed {
    logic [SSET_VAL_W-1:0] entry;
    logic                  valid;
    logic                  lt;
  } sset_link_t;

  // row-wide control broadcast
  typedef struct packed {
    logic cmp;
    logic ins;
  } sset_ctl_t;

endpackage
`default_nettype wire

### sv/sset_cell.sv
// one storage cell of the sorted row: compare against the request and shift up on insert
`default_nettype none
module sset_cell
  import sset_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sset_ctl_t             ctl_i,
  input  wire logic [SSET_VAL_W-1:0] value_i,
  input  wire sset_link_t            left_i,
  output sset_link_t                 link_o,
  output logic                       eq_o
);

  logic [SSET_VAL_W-1:0] entry_q;
  logic                  valid_q;
  logic                  lt_q;
  logic                  eq_q;
  logic                  lt_d;
  logic                  eq_d;

  assign lt_d = valid_q && ($signed(entry_q) < $signed(value_i));
  assign eq_d = valid_q && (entry_q == value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else if (ctl_i.cmp) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end else if (ctl_i.ins && !lt_q) begin
      // boundary cell takes the new value, cells above take the left entry
      valid_q <= left_i.lt ? 1'b1 : left_i.valid;
    end
  end

  // entries carry no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && !lt_q) begin
      entry_q <= left_i.lt ? value_i : left_i.entry;
    end
  end

  assign link_o.entry = entry_q;
  assign link_o.valid = valid_q;
  assign link_o.lt    = lt_q;
  assign eq_o         = eq_q;

endmodule
`default_nettype wire

### sv/sset_encode.sv
// turns the less-than thermometer of the row into a position and a hit flag
`default_nettype none
module sset_encode
  import sset_pkg::*;
#(
  parameter int unsigned CAPACITY = SSET_CAPACITY,
  parameter int unsigned PW       = $clog2(CAPACITY + 1)
) (
  input  wire logic [CAPACITY-1:0] lt_i,
  input  wire logic [CAPACITY-1:0] eq_i,
  output logic [PW-1:0]            pos_o,
  output logic                     hit_o
);

  logic [CAPACITY+1:0] therm;

  // sentinel one below the row, sentinel zero above it
  assign therm = {1'b0, lt_i, 1'b1};

  always_comb begin
    pos_o = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (therm[i] && !therm[i+1]) begin
        pos_o = pos_o | PW'(i);
      end
    end
  end

  assign hit_o = |eq_i;

endmodule
`default_nettype wire

### sv/sorted_set_insert.sv
// top level of the sorted set insert block: cell row, encoder, control and result register
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata[31:0] value (signed)
//  m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata position, count; tuser status
//
// each request passes three steps: accept, compare in every cell, then commit (shift and
// insert in the cell row) while the result is loaded into the output register.
// the compare-then-commit pass over the cell row ends before the next request is accepted.
// a waiting result does not block the next request; its commit waits for the output register.
// reset clears the valid bit of every cell and the count at once, no clearing pass.
`default_nettype none
module sorted_set_insert
  import sset_pkg::*;
#(
  parameter int unsigned CAPACITY = SSET_CAPACITY
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // value[31:0]
  input  wire logic [SSET_VAL_W-1:0]   s_axis_tdata_i,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // position[6:0], count[13:7], zero pad[15:14]
  output logic [15:0]                  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i
);

  `include "sorted_set_insert_defines.svh"

  localparam int unsigned PW = $clog2(CAPACITY + 1);

  fsm_e                  state_q, state_d;
  logic [SSET_VAL_W-1:0] value_q;
  logic [PW-1:0]         count_q;
  logic [PW-1:0]         pos;
  logic                  hit;
  logic                  full;
  logic                  out_free;
  logic                  upd_fire;
  sset_ctl_t             ctl;
  status_e               status_d;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [SSET_FIELD_W-1:0] out_pos_q;
  logic [SSET_FIELD_W-1:0] out_count_q;

  // cell row
  sset_link_t            links [CAPACITY+1];
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;

  // below cell zero: always "less", never valid
  assign links[0].entry = '0;
  assign links[0].valid = 1'b0;
  assign links[0].lt    = 1'b1;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sset_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .value_i (value_q),
      .left_i  (links[g]),
      .link_o  (links[g+1]),
      .eq_o    (eq_vec[g])
    );
    assign lt_vec[g] = links[g+1].lt;
  end

  sset_encode #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_encode (
    .lt_i  (lt_vec),
    .eq_i  (eq_vec),
    .pos_o (pos),
    .hit_o (hit)
  );

  // top cell holds an entry only when the set is full
  assign full = links[CAPACITY].valid;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign upd_fire = (state_q == FSM_UPD) && out_free;

  assign ctl.cmp = (state_q == FSM_CMP);
  assign ctl.ins = upd_fire && !hit && !full;

  // duplicate check comes before the capacity check
  always_comb begin
    if (hit) begin
      status_d = ST_PRESENT;
    end else if (full) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: begin
        state_d = FSM_UPD;
      end
      FSM_UPD: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl.ins) begin
        count_q <= count_q + PW'(1);
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      value_q <= s_axis_tdata_i;
    end
    if (upd_fire) begin
      out_status_q <= status_d;
      out_pos_q    <= SSET_FIELD_W'(pos);
      out_count_q  <= ctl.ins ? SSET_FIELD_W'(count_q + PW'(1)) : SSET_FIELD_W'(count_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_count_q, out_pos_q};
  assign m_axis_tuser_o  = out_status_q;

  // the full flag of the row and the count agree
  `SSET_ASSERT(a_full_count, full == (count_q == PW'(CAPACITY)))
  // an insert raises the count by exactly one
  `SSET_ASSERT_NEXT(a_count_step, ctl.ins, count_q == $past(count_q) + PW'(1))
  // a matching entry can never sit at the end of the list
  `SSET_ASSERT(a_hit_pos, !(upd_fire && hit && (pos == count_q)))

endmodule
`default_nettype wire

### dv/tb_sorted_set_insert.sv
// self-checking stream testbench of the sorted set insert block
`timescale 1ns / 100ps

module tb_sorted_set_insert;
  import sset_pkg::*;

  localparam int unsigned RANDOM_REQS  = 1400;
  localparam int unsigned CALM_REQS    = 150;     // tail of the run without idling
  localparam int unsigned LONG_STALL   = 300;     // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned TIMEOUT_NS   = 4_000_000;

  localparam logic [SSET_VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [SSET_VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  typedef struct packed {
    status_e                 status;
    logic [SSET_FIELD_W-1:0] position;
    logic [SSET_FIELD_W-1:0] count;
  } insert_result_t;

  // one row of the directed table; pinned rows carry a hand-typed result
  typedef struct {
    logic [SSET_VAL_W-1:0] value;
    bit                    pinned;
    insert_result_t        result;
  } directed_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [SSET_VAL_W-1:0] s_axis_tdata_i  = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [15:0]           m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;

  sorted_set_insert uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // shadow copy of the sorted set, updated at every accepted request
  logic signed [SSET_VAL_W-1:0] shadow_set [SSET_CAPACITY];
  int unsigned                  shadow_size = 0;

  insert_result_t pending_results [$];
  directed_row_t  directed_rows [$];
  int unsigned    mismatches = 0;

  // request currently offered: pinned rows override the shadow prediction
  bit             cur_pinned = 1'b0;
  insert_result_t cur_pinned_result;

  bit idle_en   = 1'b1;
  bit stall_req = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sorted_set_insert test failed");
    $finish;
  end

  // search for the first entry not below v, then insert unless present or full
  function automatic insert_result_t predict_insert(input logic signed [SSET_VAL_W-1:0] v);
    int unsigned    pos;
    insert_result_t res;
    pos = 0;
    while (pos < shadow_size && shadow_set[pos] < v) pos++;
    if (pos < shadow_size && shadow_set[pos] == v) begin
      res.status = ST_PRESENT;
    end else if (shadow_size >= SSET_CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      for (int unsigned k = shadow_size; k > pos; k--) shadow_set[k] = shadow_set[k-1];
      shadow_set[pos] = v;
      shadow_size++;
      res.status = ST_INSERTED;
    end
    res.position = SSET_FIELD_W'(pos);
    res.count    = SSET_FIELD_W'(shadow_size);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // prediction at request acceptance, checking at result acceptance
  always @(posedge clk_i) begin : scoreboard
    insert_result_t got;
    insert_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = predict_insert(s_axis_tdata_i);
        if (cur_pinned) want = cur_pinned_result;
        pending_results.push_back(want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status   = status_e'(m_axis_tuser_o);
        got.position = m_axis_tdata_o[6:0];
        got.count    = m_axis_tdata_o[13:7];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", {30'd0, got.status}, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
          if (got.position != want.position)
            report_mismatch("position", {25'd0, got.position}, {25'd0, want.position});
          if (got.count != want.count)
            report_mismatch("count", {25'd0, got.count}, {25'd0, want.count});
        end
      end
    end
  end

  // result side: short random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk_i);
        stall_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // offer one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [SSET_VAL_W-1:0] v, input bit pinned,
                              input insert_result_t pinned_res);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_pinned        = pinned;
    cur_pinned_result = pinned_res;
    s_axis_tdata_i  <= v;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic add_row(input logic [SSET_VAL_W-1:0] v, input bit pinned,
                         input status_e st, input int unsigned pos, input int unsigned cnt);
    directed_row_t row;
    row.value           = v;
    row.pinned          = pinned;
    row.result.status   = st;
    row.result.position = SSET_FIELD_W'(pos);
    row.result.count    = SSET_FIELD_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // random value: mostly duplicates of stored entries while filling, so the set
  // fills over several hundred requests; the top value is kept out until full,
  // so a drop past the last entry can occur
  function automatic logic [SSET_VAL_W-1:0] pick_value();
    logic [SSET_VAL_W-1:0] v;
    int unsigned           dup_pct;
    bit                    full;
    full    = (shadow_size >= SSET_CAPACITY);
    dup_pct = full ? 50 : 88;
    if (shadow_size > 0 && $urandom_range(0, 99) < dup_pct) begin
      v = shadow_set[$urandom_range(0, shadow_size - 1)];
    end else begin
      case ($urandom_range(0, 4))
        0: v = shadow_size > 0 ? shadow_set[$urandom_range(0, shadow_size - 1)] + 1 : 32'd1;
        1: v = shadow_size > 0 ? shadow_set[$urandom_range(0, shadow_size - 1)] - 1 : 32'd0;
        2: v = 32'($urandom_range(0, 15)) - 32'd8;
        3: begin
          case ($urandom_range(0, 3))
            0: v = VAL_MIN;
            1: v = VAL_MIN + 1;
            2: v = VAL_MAX - 1;
            default: v = VAL_MAX;
          endcase
        end
        default: v = $urandom;
      endcase
    end
    if (!full && v == VAL_MAX) v = VAL_MAX - 1;
    return v;
  endfunction

  initial begin : stimulus
    insert_result_t no_pin;
    no_pin = '{status: ST_INSERTED, position: '0, count: '0};

    // after reset, extremes and duplicates are typed in; the rest is predicted
    add_row(32'h0000_0000, 1'b1, ST_INSERTED, 0, 1);
    add_row(32'h0000_0000, 1'b1, ST_PRESENT,  0, 1);
    add_row(VAL_MIN,       1'b1, ST_INSERTED, 0, 2);
    add_row(VAL_MIN,       1'b1, ST_PRESENT,  0, 2);
    add_row(32'hffff_ffff, 1'b0, ST_INSERTED, 0, 0);
    add_row(32'h0000_0001, 1'b0, ST_INSERTED, 0, 0);
    add_row(VAL_MIN + 1,   1'b0, ST_INSERTED, 0, 0);
    add_row(VAL_MAX - 1,   1'b0, ST_INSERTED, 0, 0);
    add_row(32'h5555_5555, 1'b0, ST_INSERTED, 0, 0);
    add_row(32'haaaa_aaaa, 1'b0, ST_INSERTED, 0, 0);
    add_row(32'hffff_ffff, 1'b0, ST_INSERTED, 0, 0);
    add_row(VAL_MAX - 1,   1'b0, ST_INSERTED, 0, 0);
    add_row(32'h0000_0002, 1'b0, ST_INSERTED, 0, 0);
    add_row(32'hffff_fffe, 1'b0, ST_INSERTED, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].pinned, directed_rows[i].result);

    // sender pause: let every pending result come back
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // long receiver hold-off while requests keep coming, to back up the block
    stall_req = 1'b1;
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - CALM_REQS) idle_en = 1'b0;
      send_request(pick_value(), 1'b0, no_pin);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("sorted_set_insert test passed");
    end else begin
      $display("sorted_set_insert test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sset_pkg.sv
sv/sset_cell.sv
sv/sset_encode.sv
sv/sorted_set_insert.sv
dv/tb_sorted_set_insert.sv
